@@ src/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, skipped while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/iumr_pkg.sv @@
// Shared types, constants and a helper function for the icon upscaler.
package iumr_pkg;

  // Default geometry
  localparam int SOURCE_SIDE_DEF  = 16;
  localparam int SCALE_FACTOR_DEF = 15;

  // Widest store address over the supported source sides (up to 64x64)
  localparam int ADDR_MAX_W = 12;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // RGB565 field masks
  localparam logic [4:0] MASK5 = 5'h1F;
  localparam logic [5:0] MASK6 = 6'h3F;

  // Item kinds
  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_EMIT    = 2'd1,
    KIND_RESTART = 2'd2
  } kind_t;

  // Source formats
  typedef enum logic {
    FMT_RGBA8888 = 1'b0,
    FMT_RGB565   = 1'b1
  } fmt_t;

  // Operations carried by the queue
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  // Input transaction
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  slot;
    logic [31:0] source_word;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic [7:0] blue_byte;
    logic [7:0] green_byte;
    logic [7:0] red_byte;
    logic       frame_end;
  } out_item_t;

  // Command from front to back
  typedef struct packed {
    op_t                   op;
    logic [ADDR_MAX_W-1:0] addr;
    logic [31:0]           word;
    logic                  last;
  } cmd_t;

  // Exact x / 255 for any x up to 255 * 255, built from shifts and adds
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = 17'(x) + 17'(x >> 8) + 17'd1;
    return s[15:8];
  endfunction

endpackage

@@ src/iumr_queue.sv @@
// Short command queue that decouples the front from the back.
module iumr_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  iumr_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output iumr_pkg::cmd_t head,
  output logic          empty
);

  localparam int DEPTH = iumr_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  iumr_pkg::cmd_t entry_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign head    = entry_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed command
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ src/iumr_front.sv @@
// Front end: accepts transactions, tracks the output position, issues commands.
module iumr_front #(
  parameter int SOURCE_SIDE  = iumr_pkg::SOURCE_SIDE_DEF,
  parameter int SCALE_FACTOR = iumr_pkg::SCALE_FACTOR_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  iumr_pkg::in_item_t in_item,
  input  logic               q_full,
  output logic               push,
  output iumr_pkg::cmd_t     push_cmd
);

  localparam int DEPTH = SOURCE_SIDE * SOURCE_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(SOURCE_SIDE);
  localparam int SCW   = (SCALE_FACTOR > 1) ? $clog2(SCALE_FACTOR) : 1;
  localparam int AMW   = iumr_pkg::ADDR_MAX_W;

  // Position split into source cell and step within the cell
  logic [SCW-1:0] sub_x_r, sub_x_nxt;
  logic [SCW-1:0] sub_y_r, sub_y_nxt;
  logic [SW-1:0]  src_x_r, src_x_nxt;
  logic [SW-1:0]  src_y_r, src_y_nxt;

  logic          accept;
  logic          end_x, end_y, last;
  logic [AW-1:0] read_idx;

  assign accept = start && !q_full;
  assign end_x  = (sub_x_r == SCW'(SCALE_FACTOR - 1)) && (src_x_r == SW'(SOURCE_SIDE - 1));
  assign end_y  = (sub_y_r == SCW'(SCALE_FACTOR - 1)) && (src_y_r == SW'(SOURCE_SIDE - 1));
  assign last   = end_x && end_y;

  // Mirror the column and form the store address
  assign read_idx = AW'(src_y_r) * AW'(SOURCE_SIDE)
                  + AW'(SW'(SOURCE_SIDE - 1) - src_x_r);

  // Classify the transaction, build the command and step the position
  always_comb begin
    push      = 1'b0;
    push_cmd  = '0;
    sub_x_nxt = sub_x_r;
    sub_y_nxt = sub_y_r;
    src_x_nxt = src_x_r;
    src_y_nxt = src_y_r;
    if (accept) begin
      case (in_item.kind)
        iumr_pkg::KIND_LOAD: begin
          if (13'(in_item.slot) < 13'(DEPTH)) begin
            push          = 1'b1;
            push_cmd.op   = iumr_pkg::OP_WRITE;
            push_cmd.addr = AMW'(in_item.slot);
            push_cmd.word = in_item.source_word;
          end
        end
        iumr_pkg::KIND_EMIT: begin
          push          = 1'b1;
          push_cmd.op   = iumr_pkg::OP_READ;
          push_cmd.addr = AMW'(read_idx);
          push_cmd.last = last;
          if (sub_x_r == SCW'(SCALE_FACTOR - 1)) begin
            sub_x_nxt = '0;
            if (src_x_r == SW'(SOURCE_SIDE - 1)) begin
              src_x_nxt = '0;
              if (sub_y_r == SCW'(SCALE_FACTOR - 1)) begin
                sub_y_nxt = '0;
                src_y_nxt = (src_y_r == SW'(SOURCE_SIDE - 1)) ? '0 : src_y_r + 1'b1;
              end else begin
                sub_y_nxt = sub_y_r + 1'b1;
              end
            end else begin
              src_x_nxt = src_x_r + 1'b1;
            end
          end else begin
            sub_x_nxt = sub_x_r + 1'b1;
          end
        end
        iumr_pkg::KIND_RESTART: begin
          sub_x_nxt = '0;
          sub_y_nxt = '0;
          src_x_nxt = '0;
          src_y_nxt = '0;
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_x_r <= '0;
      sub_y_r <= '0;
      src_x_r <= '0;
      src_y_r <= '0;
    end else begin
      sub_x_r <= sub_x_nxt;
      sub_y_r <= sub_y_nxt;
      src_x_r <= src_x_nxt;
      src_y_r <= src_y_nxt;
    end
  end

endmodule

@@ src/iumr_back.sv @@
// Back end: source store, color expansion and the result register.
module iumr_back #(
  parameter int SOURCE_SIDE = iumr_pkg::SOURCE_SIDE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  iumr_pkg::fmt_t      fmt,
  input  logic                q_empty,
  input  iumr_pkg::cmd_t      head,
  output logic                pop,
  output logic                out_valid,
  output iumr_pkg::out_item_t out_item
);

  localparam int DEPTH = SOURCE_SIDE * SOURCE_SIDE;
  localparam int AW    = $clog2(DEPTH);

  logic [31:0] store_mem [DEPTH];

  // Read stage
  logic        rd_valid_r;
  logic        rd_last_r;
  logic [31:0] rd_word_r;

  // Multiply stage
  logic        mul_valid_r;
  logic        mul_last_r;
  logic [15:0] prod_r_r, prod_g_r, prod_b_r;
  logic [7:0]  exp_r_r, exp_g_r, exp_b_r;

  // Result stage
  logic                out_valid_r;
  iumr_pkg::out_item_t out_item_r, out_item_nxt;

  logic [AW-1:0] addr;
  logic          is_read;

  // Drain the queue every cycle; the receiver never stalls
  assign pop     = !q_empty;
  assign addr    = head.addr[AW-1:0];
  assign is_read = pop && (head.op == iumr_pkg::OP_READ);

  // Write the store
  always_ff @(posedge clk) begin
    if (pop && head.op == iumr_pkg::OP_WRITE) begin
      store_mem[addr] <= head.word;
    end
  end

  // Read the store
  always_ff @(posedge clk) begin
    if (is_read) begin
      rd_word_r <= store_mem[addr];
      rd_last_r <= head.last;
    end
  end

  // Multiply by alpha and expand RGB565
  always_ff @(posedge clk) begin
    prod_r_r   <= rd_word_r[31:24] * rd_word_r[7:0];
    prod_g_r   <= rd_word_r[23:16] * rd_word_r[7:0];
    prod_b_r   <= rd_word_r[15:8] * rd_word_r[7:0];
    exp_r_r    <= {rd_word_r[15:11] & iumr_pkg::MASK5, 3'b000};
    exp_g_r    <= {rd_word_r[10:5] & iumr_pkg::MASK6, 2'b00};
    exp_b_r    <= {rd_word_r[4:0] & iumr_pkg::MASK5, 3'b000};
    mul_last_r <= rd_last_r;
  end

  // Divide by 255 or pick the expanded bytes
  always_comb begin
    out_item_nxt.frame_end = mul_last_r;
    if (fmt == iumr_pkg::FMT_RGB565) begin
      out_item_nxt.red_byte   = exp_r_r;
      out_item_nxt.green_byte = exp_g_r;
      out_item_nxt.blue_byte  = exp_b_r;
    end else begin
      out_item_nxt.red_byte   = iumr_pkg::div255(prod_r_r);
      out_item_nxt.green_byte = iumr_pkg::div255(prod_g_r);
      out_item_nxt.blue_byte  = iumr_pkg::div255(prod_b_r);
    end
  end

  always_ff @(posedge clk) begin
    if (mul_valid_r) begin
      out_item_r <= out_item_nxt;
    end
  end

  // Advance the valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r  <= 1'b0;
      mul_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_valid_r  <= is_read;
      mul_valid_r <= rd_valid_r;
      out_valid_r <= mul_valid_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ src/icon_upscale_mirror_renderer.sv @@
// Top level: mirrored nearest-neighbor icon upscaler.
// A pixel request's result passes the queue entry, read, multiply and result registers.
// Throughput: one transaction per cycle; the back drains the command queue every
// cycle, so busy rises only if the queue fills. Loads and restarts give no result.
// Reset (rst_n low, synchronous) clears the position, the queue and the format
// register; the source store keeps its contents and is undefined until loaded.
module icon_upscale_mirror_renderer #(
  parameter int SOURCE_SIDE  = iumr_pkg::SOURCE_SIDE_DEF,
  parameter int SCALE_FACTOR = iumr_pkg::SCALE_FACTOR_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  iumr_pkg::in_item_t  in_item,
  output logic                out_valid,
  output iumr_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic                cfg_wdata
);

  iumr_pkg::fmt_t fmt_r;
  iumr_pkg::cmd_t push_cmd, head;
  logic           push, pop, q_full, q_empty;

  // Hold the source format register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= iumr_pkg::FMT_RGBA8888;
    end else if (cfg_we) begin
      fmt_r <= iumr_pkg::fmt_t'(cfg_wdata);
    end
  end

  assign busy = q_full;

  iumr_front #(
    .SOURCE_SIDE  (SOURCE_SIDE),
    .SCALE_FACTOR (SCALE_FACTOR)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_item  (in_item),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  iumr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty)
  );

  iumr_back #(
    .SOURCE_SIDE (SOURCE_SIDE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .fmt       (fmt_r),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

@@ src/iumr_checker.sv @@
// Port-level checker for the icon upscaler, bound to the top level.
`include "assert_macros.svh"

module iumr_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input iumr_pkg::in_item_t  in_item,
  input logic                out_valid
);

  logic emit_accept;

  assign emit_accept = start && !busy && (in_item.kind == iumr_pkg::KIND_EMIT);

  // Reset drops the result strobe
  `ASSERT_CLK_ALWAYS(a_reset_clears_strobe, !rst_n |=> !out_valid, "strobe after reset")

  // Every accepted pixel request gives a result
  `ASSERT_CLK(a_emit_gives_result, emit_accept |-> ##4 out_valid, "missing result")

  // No result without an earlier accepted pixel request
  `ASSERT_CLK(a_result_has_emit, out_valid |-> $past(emit_accept, 4), "spurious result")

  // The queue drains every cycle, so it never refuses a transaction
  `ASSERT_CLK(a_never_busy, !busy, "queue filled up")

endmodule

bind icon_upscale_mirror_renderer iumr_checker u_iumr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid)
);

@@ tb/sv/tb_icon_upscale_mirror_renderer.sv @@
// Self-checking testbench for the mirrored 15x icon upscaler with a pixel scoreboard.
`timescale 1ns / 1ps

module tb_icon_upscale_mirror_renderer;
  import iumr_pkg::*;

  localparam int        SIDE          = SOURCE_SIDE_DEF;
  localparam int        SCALE         = SCALE_FACTOR_DEF;
  localparam int        FRAME_SIDE    = SIDE * SCALE;
  localparam int        SLOT_COUNT    = SIDE * SIDE;
  localparam int        ALPHA_FULL    = 255;
  localparam logic [1:0] KIND_UNUSED  = 2'd3;
  localparam int        PHASE_ITEMS   = 200;
  localparam int        SETTLE_CYCLES = 10;
  localparam int        DRAIN_LIMIT   = 2000;
  // First output column of each row reads the rightmost source column.
  localparam logic [7:0] CORNER_SLOT  = 8'(SIDE - 1);

  // Predict upscaled pixels and hold them until the block sends them.
  class pixel_scoreboard;
    logic [31:0] icon_words [SLOT_COUNT];
    int          column;
    int          row;
    fmt_t        fmt;
    out_item_t   expected_pixels [$];
    int          errors;

    function new();
      column = 0;
      row    = 0;
      fmt    = FMT_RGBA8888;
      errors = 0;
    endfunction

    function logic [7:0] scale_by_alpha(logic [7:0] chan, logic [7:0] alpha);
      int unsigned prod;
      prod = chan;
      prod = prod * alpha;
      return 8'(prod / ALPHA_FULL);
    endfunction

    // Apply one accepted transaction to the predicted state.
    function void note_item(in_item_t item);
      int          idx;
      logic [31:0] w;
      out_item_t   px;
      case (item.kind)
        KIND_LOAD: icon_words[item.slot] = item.source_word;
        KIND_RESTART: begin
          column = 0;
          row    = 0;
        end
        KIND_EMIT: begin
          idx = (row / SCALE) * SIDE + (SIDE - 1 - column / SCALE);
          w   = icon_words[idx];
          if (fmt == FMT_RGBA8888) begin
            px.red_byte   = scale_by_alpha(w[31:24], w[7:0]);
            px.green_byte = scale_by_alpha(w[23:16], w[7:0]);
            px.blue_byte  = scale_by_alpha(w[15:8], w[7:0]);
          end else begin
            px.red_byte   = {w[15:11], 3'b000};
            px.green_byte = {w[10:5], 2'b00};
            px.blue_byte  = {w[4:0], 3'b000};
          end
          px.frame_end = (column == FRAME_SIDE - 1) && (row == FRAME_SIDE - 1);
          expected_pixels.push_back(px);
          // Advance in raster order, wrap after the last pixel
          if (column == FRAME_SIDE - 1) begin
            column = 0;
            row    = (row == FRAME_SIDE - 1) ? 0 : row + 1;
          end else begin
            column = column + 1;
          end
        end
        default: ;
      endcase
    endfunction

    // Compare one result against the oldest prediction.
    function void check_pixel(out_item_t got);
      out_item_t want;
      if (expected_pixels.size() == 0) begin
        $error("unexpected result: blue %0d green %0d red %0d frame_end %0b",
               got.blue_byte, got.green_byte, got.red_byte, got.frame_end);
        errors++;
        return;
      end
      want = expected_pixels.pop_front();
      if (got.blue_byte !== want.blue_byte) begin
        $error("blue_byte: expected %0d, got %0d", want.blue_byte, got.blue_byte);
        errors++;
      end
      if (got.green_byte !== want.green_byte) begin
        $error("green_byte: expected %0d, got %0d", want.green_byte, got.green_byte);
        errors++;
      end
      if (got.red_byte !== want.red_byte) begin
        $error("red_byte: expected %0d, got %0d", want.red_byte, got.red_byte);
        errors++;
      end
      if (got.frame_end !== want.frame_end) begin
        $error("frame_end: expected %0b, got %0b", want.frame_end, got.frame_end);
        errors++;
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      start     = 1'b0;
  logic      busy;
  in_item_t  in_item   = '0;
  logic      out_valid;
  out_item_t out_item;
  logic      cfg_we    = 1'b0;
  logic      cfg_wdata = 1'b0;

  pixel_scoreboard sb = new();

  icon_upscale_mirror_renderer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watch both channels at each rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_pixel(out_item);
      if (start && !busy) sb.note_item(in_item);
    end
  end

  // Hold off a hung run.
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Offer one transaction, with an optional idle gap first; return once accepted.
  task automatic send_item(input in_item_t item, input int idle_pct);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (busy);
  endtask

  task automatic send_fields(input logic [1:0] kind, input logic [7:0] slot,
                             input logic [31:0] word, input int idle_pct);
    in_item_t item;
    item.kind        = kind;
    item.slot        = slot;
    item.source_word = word;
    send_item(item, idle_pct);
  endtask

  // Drop start and wait until every predicted pixel has come back or the drain limit runs out.
  task automatic wait_idle();
    int n;
    n = 0;
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_format(input fmt_t value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.fmt = value;
  endtask

  function automatic logic [31:0] random_word();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(5))
      0: w[7:0] = 8'h00;
      1: w[7:0] = 8'hFF;
      2: w = '1;
      default: ;
    endcase
    return w;
  endfunction

  // Mostly pixel requests, with loads, restarts and unused kinds mixed in.
  function automatic in_item_t random_item();
    in_item_t item;
    int       pick;
    pick             = $urandom_range(99);
    item.slot        = 8'($urandom);
    item.source_word = random_word();
    if (pick < 72)      item.kind = KIND_EMIT;
    else if (pick < 90) item.kind = KIND_LOAD;
    else if (pick < 95) item.kind = KIND_RESTART;
    else                item.kind = KIND_UNUSED;
    return item;
  endfunction

  initial begin
    int        counted;
    in_item_t  item;
    int        idle_pct [4] = '{0, 49, 0, 37};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_format(FMT_RGB565);
    @(posedge clk);
    write_format(FMT_RGBA8888);

    // Fill the whole icon before any pixel is requested
    for (int s = 0; s < SLOT_COUNT; s++) send_fields(KIND_LOAD, 8'(s), random_word(), 0);

    // Premultiply corners: full white, zero alpha, alpha one, black, half alpha
    send_fields(KIND_LOAD, CORNER_SLOT, 32'hFFFF_FFFF, 0);
    send_fields(KIND_EMIT, '0, '0, 0);
    send_fields(KIND_LOAD, CORNER_SLOT, 32'hFFFF_FF00, 0);
    send_fields(KIND_EMIT, '0, '0, 0);
    send_fields(KIND_LOAD, CORNER_SLOT, 32'hFF80_4001, 0);
    send_fields(KIND_EMIT, '0, '0, 0);
    send_fields(KIND_LOAD, CORNER_SLOT, 32'h0000_00FF, 0);
    send_fields(KIND_EMIT, '0, '0, 0);
    send_fields(KIND_LOAD, CORNER_SLOT, 32'h1234_5680, 0);
    send_fields(KIND_EMIT, '0, '0, 0);
    send_fields(KIND_UNUSED, 8'hFF, 32'hFFFF_FFFF, 0);
    send_fields(KIND_EMIT, '0, '0, 0);
    send_fields(KIND_RESTART, 8'hFF, 32'hFFFF_FFFF, 0);
    send_fields(KIND_EMIT, '0, '0, 0);
    wait_idle();

    // RGB565 fields one at a time; upper half of the word must be ignored
    write_format(FMT_RGB565);
    send_fields(KIND_LOAD, CORNER_SLOT, 32'hFFFF_FFFF, 0);
    send_fields(KIND_EMIT, '0, '0, 0);
    send_fields(KIND_LOAD, CORNER_SLOT, 32'hA5A5_F800, 0);
    send_fields(KIND_EMIT, '0, '0, 0);
    send_fields(KIND_LOAD, CORNER_SLOT, 32'h0000_07E0, 0);
    send_fields(KIND_EMIT, '0, '0, 0);
    send_fields(KIND_LOAD, CORNER_SLOT, 32'h5A5A_001F, 0);
    send_fields(KIND_EMIT, '0, '0, 0);
    send_fields(KIND_RESTART, '0, '0, 0);

    // Sweep one full row plus one pixel to see the row wrap
    for (int p = 0; p < FRAME_SIDE + 1; p++) send_fields(KIND_EMIT, '0, '0, 0);
    send_fields(KIND_RESTART, '0, '0, 0);
    wait_idle();

    // Random phases, alternating formats and idle patterns
    for (int ph = 0; ph < 4; ph++) begin
      write_format((ph % 2 == 0) ? FMT_RGBA8888 : FMT_RGB565);
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        item = random_item();
        send_item(item, idle_pct[ph]);
        if (item.kind != KIND_UNUSED) counted++;
      end
      wait_idle();
    end

    if (sb.pending() > 0) begin
      $error("%0d predicted pixels never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ icon_upscale_mirror_renderer.f @@
+incdir+src
src/iumr_pkg.sv
src/iumr_queue.sv
src/iumr_front.sv
src/iumr_back.sv
src/icon_upscale_mirror_renderer.sv
src/iumr_checker.sv
tb/sv/tb_icon_upscale_mirror_renderer.sv
